[design/mwap_pkg.sv]
// Shared types and constants for the multichannel window average and peak core.
`default_nettype none
package mwap_pkg;

	// Default geometry
	localparam int CHANNELS_DEF = 5;
	localparam int WINDOW_DEF   = 8;

	// Fixed field widths
	localparam int CHAN_W   = 3;
	localparam int SLOT_W   = 3;
	localparam int SAMPLE_W = 12;
	localparam int PEAK_W   = 13;
	localparam int FRAC_W   = 16;
	localparam int AVG_W    = 12;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTION   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_START = 1'd1;

	// Register reset values
	localparam logic [FRAC_W-1:0] FRACTION_RESET   = 16'd40632;
	localparam logic [PEAK_W-1:0] PEAK_START_RESET = 13'd4096;

	// Result queue depth; covers the pipeline latency at full rate
	localparam int RES_DEPTH = 8;

	// Control that travels with an item down the pipeline
	typedef struct packed {
		logic vld;
		logic inr;
	} item_ctl_t;

	// One result, average in the lowest bits
	typedef struct packed {
		logic              active;
		logic [PEAK_W-1:0] peak;
		logic [AVG_W-1:0]  average;
	} res_t;

endpackage
`default_nettype wire

[design/mwap_update.sv]
// Window and channel memories with read-modify-write, forwarding and clearing pass.
`default_nettype none
module mwap_update
	import mwap_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int WINDOW   = WINDOW_DEF,
	parameter int SUMW     = SAMPLE_W + $clog2(WINDOW)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_acc,
	input  wire logic [CHAN_W-1:0]   chan,
	input  wire logic [SLOT_W-1:0]   slot,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic [PEAK_W-1:0]   peak_start,
	input  wire logic                peak_reload,
	output logic                     clr_busy,
	output item_ctl_t                ctl_s2,
	output logic [SUMW-1:0]          sum_s2,
	output logic [PEAK_W-1:0]        peak_s2,
	output logic [SAMPLE_W-1:0]      smp_s2
);

	localparam int DEPTH = CHANNELS * WINDOW;
	localparam int WA    = $clog2(DEPTH);
	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW    = $clog2(WINDOW);
	localparam int CMW   = SUMW + PEAK_W;

	// Memories
	logic [SAMPLE_W-1:0] win_mem [DEPTH];
	logic [CMW-1:0]      ch_mem  [CHANNELS];
	logic [SAMPLE_W-1:0] win_rd;
	logic [CMW-1:0]      ch_rd;

	// Clearing pass
	logic          clr_q;
	logic [WA-1:0] clr_cnt_q;

	// Stage 0 address decode
	logic          inr_s0;
	logic [CW-1:0] chx_s0;
	logic [WA-1:0] wad_s0;

	// Stage 1
	logic                vld_s1;
	logic                inr_s1;
	logic [CW-1:0]       chx_s1;
	logic [WA-1:0]       wad_s1;
	logic [SAMPLE_W-1:0] smp_s1;

	logic                fwd_win;
	logic                fwd_ch;
	logic [SAMPLE_W-1:0] old_w;
	logic [SUMW-1:0]     old_sum;
	logic [PEAK_W-1:0]   old_pk;
	logic [SUMW-1:0]     new_sum;
	logic [PEAK_W-1:0]   new_pk;
	logic [CHANNELS-1:0] peak_vld_q;
	logic                upd_we;

	// Stage 2 address copies for forwarding
	logic [CW-1:0] chx_s2;
	logic [WA-1:0] wad_s2;

	// Memory write port
	logic                win_we;
	logic [WA-1:0]       win_wa;
	logic [SAMPLE_W-1:0] win_wd;
	logic                ch_we;
	logic [CW-1:0]       ch_wa;
	logic [CMW-1:0]      ch_wd;

	assign clr_busy = clr_q;

	// Decode channel and slot; out of range items touch nothing
	always_comb begin
		inr_s0 = (32'(chan) < CHANNELS) && (32'(slot) < WINDOW);
		chx_s0 = inr_s0 ? CW'(chan) : '0;
		wad_s0 = inr_s0 ? WA'(32'(CW'(chan)) * WINDOW + 32'(SW'(slot))) : '0;
	end

	// Sweep both memories to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == WA'(DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Pick old values, forwarding the write that landed at the read edge
	always_comb begin
		fwd_win = ctl_s2.vld && ctl_s2.inr && (wad_s2 == wad_s1);
		fwd_ch  = ctl_s2.vld && ctl_s2.inr && (chx_s2 == chx_s1);
		old_w   = fwd_win ? smp_s2 : win_rd;
		if (fwd_ch) begin
			old_sum = sum_s2;
			old_pk  = peak_s2;
		end else begin
			old_sum = ch_rd[CMW-1:PEAK_W];
			old_pk  = peak_vld_q[chx_s1] ? ch_rd[PEAK_W-1:0] : peak_start;
		end
		new_sum = old_sum + SUMW'(smp_s1) - SUMW'(old_w);
		new_pk  = (PEAK_W'(smp_s1) > old_pk) ? PEAK_W'(smp_s1) : old_pk;
		upd_we  = vld_s1 && inr_s1;
	end

	// Select write source: clearing pass or item update
	always_comb begin
		if (clr_q) begin
			win_we = 1'b1;
			win_wa = clr_cnt_q;
			win_wd = '0;
			ch_we  = 32'(clr_cnt_q) < CHANNELS;
			ch_wa  = CW'(clr_cnt_q);
			ch_wd  = '0;
		end else begin
			win_we = upd_we;
			win_wa = wad_s1;
			win_wd = smp_s1;
			ch_we  = upd_we;
			ch_wa  = chx_s1;
			ch_wd  = {new_sum, new_pk};
		end
	end

	// Window memory
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[win_wa] <= win_wd;
		end
		win_rd <= win_mem[wad_s0];
	end

	// Channel memory: running sum and peak
	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch_mem[ch_wa] <= ch_wd;
		end
		ch_rd <= ch_mem[chx_s0];
	end

	// Peak valid bits: cleared at reset and on a peak start write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_vld_q <= '0;
		end else if (peak_reload) begin
			peak_vld_q <= '0;
		end else if (upd_we) begin
			peak_vld_q[chx_s1] <= 1'b1;
		end
	end

	// Advance pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			ctl_s2.vld <= 1'b0;
			ctl_s2.inr <= 1'b0;
		end else begin
			vld_s1     <= in_acc;
			ctl_s2.vld <= vld_s1;
			ctl_s2.inr <= inr_s1;
		end
	end

	// Advance pipeline payload
	always_ff @(posedge clk) begin
		inr_s1     <= inr_s0;
		chx_s1     <= chx_s0;
		wad_s1     <= wad_s0;
		smp_s1     <= sample;
		chx_s2     <= chx_s1;
		wad_s2     <= wad_s1;
		smp_s2     <= smp_s1;
		sum_s2     <= new_sum;
		peak_s2    <= new_pk;
	end

`ifndef SYNTH
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && clr_q))
		else $error("request accepted during clearing pass");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(clr_q && clr_cnt_q == WA'(DEPTH - 1)) |=> !clr_q)
		else $error("clearing pass did not end");
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && inr_s1) |-> (32'(new_sum) <= WINDOW * 4095))
		else $error("running sum out of range");
`endif

endmodule
`default_nettype wire

[design/mwap_result.sv]
// Average by reciprocal multiply and activity test against the fraction of the peak.
`default_nettype none
module mwap_result
	import mwap_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	parameter int SUMW   = SAMPLE_W + $clog2(WINDOW)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire item_ctl_t           ctl_s2,
	input  wire logic [SUMW-1:0]     sum_s2,
	input  wire logic [PEAK_W-1:0]   peak_s2,
	input  wire logic [SAMPLE_W-1:0] smp_s2,
	input  wire logic [FRAC_W-1:0]   frac,
	output logic                     res_vld,
	output res_t                     res
);

	// floor(sum / WINDOW) = (sum * RECIP) >> K, exact for every SUMW-bit sum
	localparam int LW    = $clog2(WINDOW);
	localparam int K     = SUMW + LW;
	localparam int RECIP = ((1 << K) + WINDOW - 1) / WINDOW;
	localparam int RW    = SUMW + 1;
	localparam int PW    = SUMW + RW;
	localparam int AW    = FRAC_W + PEAK_W;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);

	logic                vld_s3;
	logic                inr_s3;
	logic [PW-1:0]       qprod_s3;
	logic [AW-1:0]       aprod_s3;
	logic [SAMPLE_W-1:0] smp_s3;
	logic [PEAK_W-1:0]   peak_s3;
	logic [AW-1:0]       lhs;

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= ctl_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		inr_s3   <= ctl_s2.inr;
		qprod_s3 <= PW'(sum_s2) * PW'(RECIP_V);
		aprod_s3 <= AW'(frac) * AW'(peak_s2);
		smp_s3   <= smp_s2;
		peak_s3  <= peak_s2;
	end

	// Shift quotient out and compare sample against fraction of peak
	always_comb begin
		lhs     = AW'({smp_s3, {FRAC_W{1'b0}}});
		res_vld = vld_s3;
		if (inr_s3) begin
			res.average = qprod_s3[K +: AVG_W];
			res.peak    = peak_s3;
			res.active  = lhs > aprod_s3;
		end else begin
			res = '0;
		end
	end

endmodule
`default_nettype wire

[design/mwap_out_fifo.sv]
// Result queue with credit count so the pipeline never has to stall.
`default_nettype none
module mwap_out_fifo
	import mwap_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_acc,
	input  wire logic wr,
	input  wire res_t wr_data,
	output logic      room,
	output logic      out_vld,
	input  wire logic out_rdy,
	output res_t      out_data
);

	localparam int PTRW = $clog2(RES_DEPTH);
	localparam int CNTW = PTRW + 1;

	res_t            buf_q [RES_DEPTH];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] occ_q;
	logic            pop;

	assign pop      = out_vld && out_rdy;
	assign out_vld  = cnt_q != '0;
	assign out_data = buf_q[rd_ptr_q];
	assign room     = occ_q < CNTW'(RES_DEPTH);

	// Hold results
	always_ff @(posedge clk) begin
		if (wr) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers, stored count and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			occ_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNTW'(wr) - CNTW'(pop);
			occ_q <= occ_q + CNTW'(in_acc) - CNTW'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && !pop && cnt_q == CNTW'(RES_DEPTH)))
		else $error("result queue overflow");
	a_credit_covers: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= occ_q)
		else $error("stored results exceed requests in flight");
`endif

endmodule
`default_nettype wire

[design/multichannel_window_average_peak_core.sv]
// Top level: stream ports, configuration registers and pipeline wiring.
// The core takes one request per clock, except while clearing or without queue room,
// and returns one result per request, in order, through stage 1, stage 2, the
// multiply stage and the result queue. Rate is set by one read-modify-write per
// request on each of two memories (window samples, and per-channel sum plus peak),
// with the write of one request forwarded to the next. After reset a clearing
// pass zeroes the memories while s_axis_tready stays low; configuration writes
// are taken at any time but must only be issued while no request is in flight.
`default_nettype none
module multichannel_window_average_peak_core
	import mwap_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int WINDOW   = WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [23:0]           s_axis_tdata,  // chan[2:0], slot[5:3], sample[17:6]
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // average[11:0], peak[24:12], active[25]
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SUMW = SAMPLE_W + $clog2(WINDOW);

	logic [FRAC_W-1:0]   frac_q;
	logic [PEAK_W-1:0]   peak_start_q;
	logic                peak_reload;
	logic                in_acc;
	logic                clr_busy;
	logic                room;
	item_ctl_t           ctl_s2;
	logic [SUMW-1:0]     sum_s2;
	logic [PEAK_W-1:0]   peak_s2;
	logic [SAMPLE_W-1:0] smp_s2;
	logic                res_vld;
	res_t                res;
	res_t                out_res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q       <= FRACTION_RESET;
			peak_start_q <= PEAK_START_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FRACTION:   frac_q       <= cfg_data;
				REG_PEAK_START: peak_start_q <= cfg_data[PEAK_W-1:0];
				default: ;
			endcase
		end
	end

	assign peak_reload   = cfg_we && (cfg_idx == REG_PEAK_START);
	assign s_axis_tready = !clr_busy && room;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata  = {6'd0, out_res};

	mwap_update #(
		.CHANNELS (CHANNELS),
		.WINDOW   (WINDOW),
		.SUMW     (SUMW)
	) u_update (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.chan        (s_axis_tdata[2:0]),
		.slot        (s_axis_tdata[5:3]),
		.sample      (s_axis_tdata[17:6]),
		.peak_start  (peak_start_q),
		.peak_reload (peak_reload),
		.clr_busy    (clr_busy),
		.ctl_s2      (ctl_s2),
		.sum_s2      (sum_s2),
		.peak_s2     (peak_s2),
		.smp_s2      (smp_s2)
	);

	mwap_result #(
		.WINDOW (WINDOW),
		.SUMW   (SUMW)
	) u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.sum_s2  (sum_s2),
		.peak_s2 (peak_s2),
		.smp_s2  (smp_s2),
		.frac    (frac_q),
		.res_vld (res_vld),
		.res     (res)
	);

	mwap_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.wr       (res_vld),
		.wr_data  (res),
		.room     (room),
		.out_vld  (m_axis_tvalid),
		.out_rdy  (m_axis_tready),
		.out_data (out_res)
	);

endmodule
`default_nettype wire

[tb/sv/tb_multichannel_window_average_peak_core.sv]
// Testbench for the multichannel window average and peak core, with its scoreboard.
`default_nettype none
module tb_multichannel_window_average_peak_core
	import mwap_pkg::*;
();

	localparam int HALF_PERIOD   = 2;
	localparam int ITEMS_PER_SET = 85;
	localparam int SETTINGS_CNT  = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int TAIL_CYCLES   = 8;

	// Tracks window, sum and peak per channel and holds the results still owed
	class avg_peak_scoreboard;
		logic [FRAC_W-1:0]   fraction;
		logic [PEAK_W-1:0]   peak_init;
		logic [SAMPLE_W-1:0] window_mem [CHANNELS_DEF][WINDOW_DEF];
		int                  window_sum [CHANNELS_DEF];
		logic [PEAK_W-1:0]   chan_peak [CHANNELS_DEF];
		res_t                owed [$];
		int                  errors;
		int                  requests;
		int                  compared;
		int                  active_cnt;

		function new();
			fraction = FRACTION_RESET;
			peak_init = PEAK_START_RESET;
			for (int c = 0; c < CHANNELS_DEF; c++) begin
				window_sum[c] = 0;
				chan_peak[c] = PEAK_START_RESET;
				for (int s = 0; s < WINDOW_DEF; s++)
					window_mem[c][s] = '0;
			end
			errors = 0;
			requests = 0;
			compared = 0;
			active_cnt = 0;
		endfunction

		// Apply a register write; a new peak start reloads every channel peak
		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRACTION) begin
				fraction = data[FRAC_W-1:0];
			end else if (idx == REG_PEAK_START) begin
				peak_init = data[PEAK_W-1:0];
				for (int c = 0; c < CHANNELS_DEF; c++)
					chan_peak[c] = peak_init;
			end
		endfunction

		// Update the channel state for one accepted request and owe its result
		function void note_request(logic [CHAN_W-1:0] ch, logic [SLOT_W-1:0] sl,
				logic [SAMPLE_W-1:0] smp);
			res_t   r;
			longint lhs;
			longint rhs;
			r = '0;
			requests++;
			if (ch < CHANNELS_DEF && sl < WINDOW_DEF) begin
				window_sum[ch] = window_sum[ch] + smp - window_mem[ch][sl];
				window_mem[ch][sl] = smp;
				if (smp > chan_peak[ch])
					chan_peak[ch] = PEAK_W'(smp);
				lhs = longint'(smp) << 16;
				rhs = longint'(fraction) * longint'(chan_peak[ch]);
				r.average = AVG_W'(window_sum[ch] / WINDOW_DEF);
				r.peak = chan_peak[ch];
				r.active = (lhs > rhs);
			end
			owed.push_back(r);
		endfunction

		// Compare one result with the oldest one owed
		function void check_result(res_t got);
			res_t want;
			if (owed.size() == 0) begin
				$error("result with nothing owed: average %0d peak %0d active %0d",
					got.average, got.peak, got.active);
				errors++;
				return;
			end
			want = owed.pop_front();
			compared++;
			if (got.active)
				active_cnt++;
			if (got.average !== want.average) begin
				$error("average mismatch: expected %0d, got %0d", want.average, got.average);
				errors++;
			end
			if (got.peak !== want.peak) begin
				$error("peak mismatch: expected %0d, got %0d", want.peak, got.peak);
				errors++;
			end
			if (got.active !== want.active) begin
				$error("active mismatch: expected %0d, got %0d", want.active, got.active);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata = '0;   // chan[2:0], slot[5:3], sample[17:6]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;        // average[11:0], peak[24:12], active[25]
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	avg_peak_scoreboard sb = new();
	int tx_idle_pct = 35;
	int rx_idle_pct = 57;
	logic hold_ask = 1'b0;
	int settings_done = 0;

	multichannel_window_average_peak_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Record accepted requests and register writes, check results, watch for stalls
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (cfg_we)
			sb.write_reg(cfg_idx, cfg_data);
		if (s_axis_tvalid && s_axis_tready)
			sb.note_request(s_axis_tdata[2:0], s_axis_tdata[5:3], s_axis_tdata[17:6]);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(res_t'(m_axis_tdata[25:0]));
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without progress", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Result side: random back-pressure plus one long hold-off on request
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offer one request after a random gap and hold it until taken
	task automatic send_item(int ch, int sl, int smp);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, SAMPLE_W'(smp), SLOT_W'(sl), CHAN_W'(ch)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait until every owed result has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Write one register; the caller lowers the write enable after the last one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
	endtask

	// Pick a sample: uniform random, near the activity threshold or the peak, or an extreme
	function automatic int pick_sample(int ch);
		int pk;
		int thr;
		int sel;
		int v;
		pk = (ch < CHANNELS_DEF) ? int'(sb.chan_peak[ch]) : 4096;
		thr = int'((longint'(sb.fraction) * longint'(pk)) >> 16);
		sel = $urandom_range(99);
		if (sel < 40)
			v = $urandom_range(4095);
		else if (sel < 55)
			v = ($urandom_range(1) != 0) ? 4095 : 0;
		else if (sel < 80)
			v = thr + $urandom_range(4) - 2;
		else
			v = pk + $urandom_range(4) - 2;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v;
	endfunction

	initial begin
		int frac_val;
		int peak_val;
		int ch;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: full-scale window, threshold edges, channels out of range
		for (int s = 0; s < WINDOW_DEF; s++)
			send_item(0, s, 4095);
		send_item(0, 0, 0);
		send_item(4, 7, 2540);
		send_item(4, 6, 2539);
		send_item(5, 3, 100);
		send_item(6, 0, 4095);
		send_item(7, 7, 4095);
		send_item(1, 2, 0);
		send_item(2, 5, 1);
		send_item(3, 4, 2048);
		send_item(0, 0, 4095);
		send_item(4, 7, 0);
		drain();

		// Random part over several register settings, extremes first
		for (int p = 0; p < SETTINGS_CNT; p++) begin
			case (p)
				0: begin frac_val = 0;     peak_val = 0;    end
				1: begin frac_val = 65535; peak_val = 4096; end
				3: begin frac_val = 40632; peak_val = 2000; end
				5: begin frac_val = 32768; peak_val = 4095; end
				default: begin
					frac_val = $urandom_range(65535);
					peak_val = $urandom_range(4096);
				end
			endcase
			write_reg(REG_FRACTION, frac_val);
			write_reg(REG_PEAK_START, peak_val);
			cfg_we <= 1'b0;
			settings_done++;
			if (p < 2) begin
				tx_idle_pct = 35;
				rx_idle_pct = 57;
			end else if (p < 4) begin
				tx_idle_pct = 57;
				rx_idle_pct = 35;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (p == 4)
				hold_ask <= 1'b1;
			for (int i = 0; i < ITEMS_PER_SET; i++) begin
				ch = ($urandom_range(9) == 0) ? $urandom_range(7, CHANNELS_DEF) :
					$urandom_range(CHANNELS_DEF - 1);
				send_item(ch, $urandom_range(WINDOW_DEF - 1), pick_sample(ch));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests over %0d register settings plus reset defaults;",
			sb.requests, settings_done);
		$display("compared %0d results, %0d of them active.", sb.compared, sb.active_cnt);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
design/mwap_pkg.sv
design/mwap_update.sv
design/mwap_result.sv
design/mwap_out_fifo.sv
design/multichannel_window_average_peak_core.sv
tb/sv/tb_multichannel_window_average_peak_core.sv
